@@ sv/psf_pkg.sv @@
package psf_pkg;

  localparam int ADDR_W    = 48;
  localparam int CNT_W     = 25;
  localparam int LEN_W     = CNT_W + 1;
  localparam int MIN_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int MASK_W    = 1 << BYTE_W;

  localparam logic [CNT_W-1:0] MAX_CHUNK_BYTES = CNT_W'(16 * 1024 * 1024);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_3     = 3'd4;

  localparam logic [MIN_W-1:0]  MIN_LENGTH_RESET = 16'd10;
  localparam logic [MASK_W-1:0] MASK_RESET = {
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_0000_0000
  };

  // Printable flags of the byte before last, the last byte and this byte.
  localparam logic [2:0] PAT_NONE       = 3'b000;
  localparam logic [2:0] PAT_FIRST      = 3'b001;
  localparam logic [2:0] PAT_LONE       = 3'b010;
  localparam logic [2:0] PAT_WIDE_START = 3'b011;
  localparam logic [2:0] PAT_WIDE_END   = 3'b100;
  localparam logic [2:0] PAT_GAP_PRINT  = 3'b101;
  localparam logic [2:0] PAT_NARROW_END = 3'b110;
  localparam logic [2:0] PAT_RUN        = 3'b111;

endpackage

@@ sv/printable_string_finder.sv @@
// An accepted byte is held in the input register; a result it gives is held in the output register.
// Throughput: one byte per cycle; in_stall rises only while a finished result
// is held by out_stall and the input register is already occupied.
// Reset (synchronous, rst_n low) empties both registers, clears the flags and
// run counter, and restores min_length and the printable table to their defaults.
module printable_string_finder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [psf_pkg::BYTE_W-1:0]    in_byte_value,
  input  logic [psf_pkg::ADDR_W-1:0]    in_byte_address,
  input  logic                          in_chunk_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [psf_pkg::ADDR_W-1:0]    out_string_address,
  output logic [psf_pkg::LEN_W-1:0]     out_length_bytes,
  output logic [psf_pkg::CNT_W-1:0]     out_char_count,
  output logic                          out_is_wide,
  input  logic                          cfg_we,
  input  logic [psf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psf_pkg::CFG_W-1:0]     cfg_wdata
);
  import psf_pkg::*;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_chunk_r;

  logic              prev_r;
  logic              prev2_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  logic [MIN_W-1:0]  min_len_r;
  logic [MASK_W-1:0] mask_r;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [ADDR_W-1:0] out_addr_nxt;
  logic [LEN_W-1:0]  out_len_r;
  logic [LEN_W-1:0]  out_len_nxt;
  logic [CNT_W-1:0]  out_chars_r;
  logic [CNT_W-1:0]  chars;
  logic              out_wide_r;
  logic              wide;

  logic              proceed;
  logic              fire;
  logic              p;
  logic              p1;
  logic              p2;
  logic [CNT_W-1:0]  cnt;
  logic              ge_min;
  logic              gt_min;
  logic              report;

  assign proceed  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && proceed;
  assign in_stall = s1_valid_r && !proceed;

  assign p1  = s1_chunk_r ? 1'b0 : prev_r;
  assign p2  = s1_chunk_r ? 1'b0 : prev2_r;
  assign cnt = s1_chunk_r ? '0 : count_r;
  assign p   = mask_r[s1_byte_r];

  assign ge_min = cnt >= CNT_W'(min_len_r);
  assign gt_min = cnt >  CNT_W'(min_len_r);

  always_comb begin
    report    = 1'b0;
    chars     = cnt;
    count_nxt = cnt;
    unique case ({p2, p1, p}) inside
      PAT_NARROW_END: begin
        if (ge_min) begin
          report = 1'b1;
        end else begin
          count_nxt = (s1_byte_r == '0) ? CNT_W'(1) : '0;
        end
      end
      PAT_WIDE_END: begin
        if (ge_min) begin
          report = 1'b1;
        end else begin
          count_nxt = '0;
        end
      end
      PAT_WIDE_START: begin
        if (gt_min) begin
          report = 1'b1;
          chars  = cnt - CNT_W'(1);
        end else begin
          count_nxt = CNT_W'(2);
        end
      end
      PAT_RUN, PAT_GAP_PRINT, PAT_FIRST: begin
        count_nxt = (cnt >= MAX_CHUNK_BYTES) ? MAX_CHUNK_BYTES : cnt + CNT_W'(1);
      end
      PAT_LONE, PAT_NONE: begin
        count_nxt = cnt;
      end
    endcase
    if (report) begin
      count_nxt = '0;
    end
  end

  assign wide         = (p1 == p);
  assign out_len_nxt  = wide ? {chars, 1'b0} : {1'b0, chars};
  assign out_addr_nxt = s1_addr_r - ADDR_W'(p) - ADDR_W'(out_len_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r  <= in_byte_value;
      s1_addr_r  <= in_byte_address;
      s1_chunk_r <= in_chunk_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      prev2_r <= 1'b0;
      count_r <= '0;
    end else if (fire) begin
      prev2_r <= p1;
      prev_r  <= p;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proceed) begin
      out_valid_r <= fire && report;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && report) begin
      out_addr_r  <= out_addr_nxt;
      out_len_r   <= out_len_nxt;
      out_chars_r <= chars;
      out_wide_r  <= wide;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LENGTH_RESET;
      mask_r    <= MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_LENGTH: min_len_r      <= cfg_wdata[MIN_W-1:0];
        REG_MASK_0:     mask_r[63:0]    <= cfg_wdata;
        REG_MASK_1:     mask_r[127:64]  <= cfg_wdata;
        REG_MASK_2:     mask_r[191:128] <= cfg_wdata;
        REG_MASK_3:     mask_r[255:192] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_string_address = out_addr_r;
  assign out_length_bytes   = out_len_r;
  assign out_char_count     = out_chars_r;
  assign out_is_wide        = out_wide_r;

endmodule

@@ sv/psf_checker.sv @@
module psf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [psf_pkg::ADDR_W-1:0]    out_string_address,
  input logic [psf_pkg::LEN_W-1:0]     out_length_bytes,
  input logic [psf_pkg::CNT_W-1:0]     out_char_count,
  input logic                          out_is_wide
);

  // A held result keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_string_address) &&
      $stable(out_length_bytes) && $stable(out_char_count) && $stable(out_is_wide))
    else $error("held result changed");

  // The input side is only held back by a blocked result.
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // A wide string takes two bytes per character, a narrow one a single byte.
  a_len_wide: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_wide |-> out_length_bytes == {out_char_count, 1'b0})
    else $error("wide length mismatch");

  a_len_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_wide |-> out_length_bytes == {1'b0, out_char_count})
    else $error("narrow length mismatch");

  // A new result stems from a request that passed the input register and then the output register.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching request");

endmodule

bind printable_string_finder psf_checker u_psf_checker (.*);
